// ===== design/wrc_pkg.sv =====
package wrc_pkg;

	// record limits
	localparam int MAX_POINTS = 4096;
	localparam int CNT_W      = 13;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_REG   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CAL       = 3'd4;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FEW      = 3'd1;
	localparam logic [2:0] ST_ZERO_DEN = 3'd2;
	localparam logic [2:0] ST_NO_POINT = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// 0.6*pi in Q2.30 (4 * pi * 0.15)
	localparam logic [63:0] PI_SCALE = 64'd2023955656;

	// dividend width: 56-bit numerator magnitude shifted by the slope fraction
	localparam int SLOPE_SH = 19;
	localparam int K_SH     = 42;
	localparam int DVD_W    = 75;

	// serial step counts (last step index)
	localparam logic [6:0] MUL_LAST = 7'd31;
	localparam logic [6:0] DIV_LAST = 7'd74;

	typedef struct packed {
		logic signed [15:0] log_time;
		logic signed [15:0] temp_rise;
		logic               last;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [31:0] conductivity;
		logic [2:0]         status;
		logic [12:0]        points_used;
	} result_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_END,
		PH_DONE
	} phase_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_EVAL,
		S_MXY,
		S_MXX,
		S_AXX,
		S_FIN,
		S_N1,
		S_N2,
		S_D1,
		S_D2,
		S_DIVS,
		S_SLP,
		S_PC,
		S_KD,
		S_DIVK,
		S_KOUT,
		S_OUT
	} state_t;

	// request to the shared adder
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic        sub;
	} alu_req_t;

endpackage

// ===== design/windowed_regression_conductivity_core.sv =====
// Channel  | Signals                              | Direction
// sample   | sample_valid, sample_ready, sample   | in  (log_time, temp_rise, last)
// result   | result_valid, result_ready, result   | out (slope, conductivity, status, points)
// cfg      | cfg_valid, cfg_ready, cfg_index/data | in  (register writes, always ready)
//
// A sample that is accumulated passes the multiply and sum states (16x16 multiplier
// used twice, 44-bit sums through the shared 64-bit adder); other samples skip them.
// A last sample adds the result math on the same adder (up to six 32-step shift-add
// products, two 75-step restoring divides).
// sample_ready is low while an item is in work; a finished result waits in the
// output register and stalls the block only if a second result is ready first.
// Reset restores the register defaults and clears all record sums.
module windowed_regression_conductivity_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  wrc_pkg::sample_t                sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output wrc_pkg::result_t                result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wrc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data
);

	wrc_pkg::state_t state_q, state_d;

	// configuration
	logic               use_reg_q;
	logic signed [15:0] win_start_q, win_end_q;
	logic [15:0]        power_q, cal_q;

	// record state
	logic signed [28:0] sx_q, sy_q;
	logic signed [43:0] sxy_q, sxx_q;
	logic [wrc_pkg::CNT_W-1:0] cnt_q;
	wrc_pkg::phase_t    phase_q;
	logic [31:0]        first_q, second_q;
	logic               ovf_q;

	// sample holding
	logic signed [15:0] x_q, y_q;
	logic               last_q;

	// shared serial datapath
	logic [63:0]               acc_q, mul_a_q;
	logic [31:0]               mul_b_q;
	logic                      mul_sub_q;
	logic [6:0]                step_q;
	logic [wrc_pkg::DVD_W-1:0] dvd_q;
	logic [62:0]               dvs_q;
	logic [62:0]               rem_q;
	logic [32:0]               quo_q;
	logic                      qovf_q;
	logic                      neg_q;

	// result staging
	logic signed [31:0] slope_q, k_q;
	logic [2:0]         status_q;
	logic [12:0]        used_q;
	wrc_pkg::result_t   result_q;
	logic               result_valid_q;

	// window and per-sample decisions
	logic signed [15:0] lo, hi;
	logic               in_win, full, acc_go;

	assign lo     = (win_end_q < win_start_q) ? win_end_q : win_start_q;
	assign hi     = (win_end_q < win_start_q) ? win_start_q : win_end_q;
	assign in_win = (x_q >= lo) && (x_q <= hi);
	assign full   = cnt_q >= wrc_pkg::CNT_W'(wrc_pkg::MAX_POINTS);
	assign acc_go = use_reg_q && (phase_q != wrc_pkg::PH_DONE) && in_win && !full;

	// product unit
	logic signed [15:0] mul_x, mul_y;
	logic signed [31:0] prod_s1;

	assign mul_x = x_q;
	assign mul_y = (state_q == wrc_pkg::S_MXY) ? y_q : x_q;

	wrc_mul u_mul (
		.clk     (clk),
		.a       (mul_x),
		.b       (mul_y),
		.prod_s1 (prod_s1)
	);

	// shared adder input select
	wrc_pkg::alu_req_t alu_req;
	logic [63:0]       alu_sum;
	logic              alu_cout;
	logic [63:0]       rem_sh;

	assign rem_sh = {rem_q, dvd_q[wrc_pkg::DVD_W-1]};

	always_comb begin
		alu_req = '0;
		case (state_q)
			wrc_pkg::S_MXX: begin
				alu_req.a = {{20{sxy_q[43]}}, sxy_q};
				alu_req.b = {{32{prod_s1[31]}}, prod_s1};
			end
			wrc_pkg::S_AXX: begin
				alu_req.a = {{20{sxx_q[43]}}, sxx_q};
				alu_req.b = {{32{prod_s1[31]}}, prod_s1};
			end
			wrc_pkg::S_N1, wrc_pkg::S_N2, wrc_pkg::S_D1, wrc_pkg::S_D2,
			wrc_pkg::S_PC, wrc_pkg::S_KD: begin
				alu_req.a   = acc_q;
				alu_req.b   = mul_a_q;
				alu_req.sub = mul_sub_q;
			end
			wrc_pkg::S_DIVS, wrc_pkg::S_DIVK: begin
				alu_req.a   = rem_sh;
				alu_req.b   = {1'b0, dvs_q};
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	wrc_alu u_alu (
		.req  (alu_req),
		.sum  (alu_sum),
		.cout (alu_cout)
	);

	// helper values
	logic [63:0]        mul_next, num_mag;
	logic               mul_end, div_end;
	logic [28:0]        sx_mag;
	logic signed [16:0] dx, dy;
	logic [16:0]        dx_mag, dy_mag;
	logic               q_sat;
	logic signed [31:0] q_val;
	logic               den_bad;
	logic               out_load;

	assign mul_next = mul_b_q[0] ? alu_sum : acc_q;
	assign num_mag  = mul_next[63] ? (64'd0 - mul_next) : mul_next;
	assign mul_end  = step_q == wrc_pkg::MUL_LAST;
	assign div_end  = step_q == wrc_pkg::DIV_LAST;
	assign sx_mag   = sx_q[28] ? (29'd0 - sx_q) : sx_q;
	assign dx       = {second_q[31], second_q[31:16]} - {first_q[31], first_q[31:16]};
	assign dy       = {second_q[15], second_q[15:0]} - {first_q[15], first_q[15:0]};
	assign dx_mag   = dx[16] ? (17'd0 - dx) : dx;
	assign dy_mag   = dy[16] ? (17'd0 - dy) : dy;
	assign den_bad  = mul_next[63] || (mul_next == 64'd0);
	assign out_load = (state_q == wrc_pkg::S_OUT) && (!result_valid_q || result_ready);

	// saturated signed quotient
	assign q_sat = qovf_q | quo_q[32] | quo_q[31];
	always_comb begin
		if (q_sat) begin
			q_val = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else if (neg_q) begin
			q_val = 32'sd0 - $signed({1'b0, quo_q[30:0]});
		end else begin
			q_val = $signed({1'b0, quo_q[30:0]});
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wrc_pkg::S_IDLE: begin
				if (sample_valid) state_d = wrc_pkg::S_EVAL;
			end
			wrc_pkg::S_EVAL: begin
				if (acc_go) state_d = wrc_pkg::S_MXY;
				else if (last_q) state_d = wrc_pkg::S_FIN;
				else state_d = wrc_pkg::S_IDLE;
			end
			wrc_pkg::S_MXY: state_d = wrc_pkg::S_MXX;
			wrc_pkg::S_MXX: state_d = wrc_pkg::S_AXX;
			wrc_pkg::S_AXX: state_d = last_q ? wrc_pkg::S_FIN : wrc_pkg::S_IDLE;
			wrc_pkg::S_FIN: begin
				if (use_reg_q) begin
					if (ovf_q || cnt_q < wrc_pkg::CNT_W'(2)) state_d = wrc_pkg::S_OUT;
					else state_d = wrc_pkg::S_N1;
				end else begin
					if (phase_q != wrc_pkg::PH_DONE || dx == 17'sd0) state_d = wrc_pkg::S_OUT;
					else state_d = wrc_pkg::S_DIVS;
				end
			end
			wrc_pkg::S_N1: if (mul_end) state_d = wrc_pkg::S_N2;
			wrc_pkg::S_N2: if (mul_end) state_d = wrc_pkg::S_D1;
			wrc_pkg::S_D1: if (mul_end) state_d = wrc_pkg::S_D2;
			wrc_pkg::S_D2: begin
				if (mul_end) state_d = den_bad ? wrc_pkg::S_OUT : wrc_pkg::S_DIVS;
			end
			wrc_pkg::S_DIVS: if (div_end) state_d = wrc_pkg::S_SLP;
			wrc_pkg::S_SLP: state_d = (q_val == 32'sd0) ? wrc_pkg::S_OUT : wrc_pkg::S_PC;
			wrc_pkg::S_PC: if (mul_end) state_d = wrc_pkg::S_KD;
			wrc_pkg::S_KD: if (mul_end) state_d = wrc_pkg::S_DIVK;
			wrc_pkg::S_DIVK: if (div_end) state_d = wrc_pkg::S_KOUT;
			wrc_pkg::S_KOUT: state_d = wrc_pkg::S_OUT;
			wrc_pkg::S_OUT: if (out_load) state_d = wrc_pkg::S_IDLE;
			default: state_d = wrc_pkg::S_IDLE;
		endcase
	end

	assign sample_ready = state_q == wrc_pkg::S_IDLE;
	assign cfg_ready    = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_reg_q   <= 1'b1;
			win_start_q <= 16'sd0;
			win_end_q   <= 16'sd32767;
			power_q     <= 16'd0;
			cal_q       <= 16'd4096;
		end else if (cfg_valid) begin
			case (cfg_index)
				wrc_pkg::CFG_USE_REG:   use_reg_q   <= cfg_data[0];
				wrc_pkg::CFG_WIN_START: win_start_q <= cfg_data;
				wrc_pkg::CFG_WIN_END:   win_end_q   <= cfg_data;
				wrc_pkg::CFG_POWER:     power_q     <= cfg_data;
				wrc_pkg::CFG_CAL:       cal_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// record state: window search, sums, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q     <= '0;
			sy_q     <= '0;
			sxy_q    <= '0;
			sxx_q    <= '0;
			cnt_q    <= '0;
			phase_q  <= wrc_pkg::PH_START;
			first_q  <= '0;
			second_q <= '0;
			ovf_q    <= 1'b0;
		end else if (out_load) begin
			sx_q     <= '0;
			sy_q     <= '0;
			sxy_q    <= '0;
			sxx_q    <= '0;
			cnt_q    <= '0;
			phase_q  <= wrc_pkg::PH_START;
			first_q  <= '0;
			second_q <= '0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				wrc_pkg::S_EVAL: begin
					if (use_reg_q) begin
						if (phase_q != wrc_pkg::PH_DONE) begin
							if (in_win && full) ovf_q <= 1'b1;
							else if (in_win) cnt_q <= cnt_q + 1'b1;
							if (x_q >= hi) phase_q <= wrc_pkg::PH_DONE;
						end
					end else begin
						case (phase_q)
							wrc_pkg::PH_START: begin
								if (x_q >= lo) begin
									first_q <= {x_q, y_q};
									phase_q <= wrc_pkg::PH_END;
								end
							end
							wrc_pkg::PH_END: begin
								if (x_q >= hi) begin
									second_q <= {x_q, y_q};
									phase_q  <= wrc_pkg::PH_DONE;
								end
							end
							default: ;
						endcase
					end
				end
				wrc_pkg::S_MXY: begin
					sx_q <= sx_q + {{13{x_q[15]}}, x_q};
					sy_q <= sy_q + {{13{y_q[15]}}, y_q};
				end
				wrc_pkg::S_MXX: sxy_q <= alu_sum[43:0];
				wrc_pkg::S_AXX: sxx_q <= alu_sum[43:0];
				default: ;
			endcase
		end
	end

	// serial multiply / divide sequencing
	always_ff @(posedge clk) begin
		case (state_q)
			wrc_pkg::S_IDLE: begin
				if (sample_valid) begin
					x_q    <= sample.log_time;
					y_q    <= sample.temp_rise;
					last_q <= sample.last;
				end
			end
			wrc_pkg::S_FIN: begin
				slope_q   <= '0;
				k_q       <= '0;
				acc_q     <= '0;
				step_q    <= '0;
				mul_a_q   <= {{20{sxy_q[43]}}, sxy_q};
				mul_b_q   <= {19'd0, cnt_q};
				mul_sub_q <= 1'b0;
				rem_q     <= '0;
				quo_q     <= '0;
				qovf_q    <= 1'b0;
				dvd_q     <= {39'd0, dy_mag, 19'd0};
				dvs_q     <= {46'd0, dx_mag};
				neg_q     <= dx[16] ^ dy[16];
				if (use_reg_q) begin
					used_q <= cnt_q;
					if (ovf_q) status_q <= wrc_pkg::ST_OVERFLOW;
					else if (cnt_q < wrc_pkg::CNT_W'(2)) status_q <= wrc_pkg::ST_FEW;
					else status_q <= wrc_pkg::ST_OK;
				end else begin
					case (phase_q)
						wrc_pkg::PH_DONE: used_q <= 13'd2;
						wrc_pkg::PH_END:  used_q <= 13'd1;
						default:          used_q <= 13'd0;
					endcase
					if (phase_q != wrc_pkg::PH_DONE) status_q <= wrc_pkg::ST_NO_POINT;
					else if (dx == 17'sd0) status_q <= wrc_pkg::ST_ZERO_DEN;
					else status_q <= wrc_pkg::ST_OK;
				end
			end
			wrc_pkg::S_N1, wrc_pkg::S_N2, wrc_pkg::S_D1, wrc_pkg::S_D2,
			wrc_pkg::S_PC, wrc_pkg::S_KD: begin
				// one shift-add step
				acc_q   <= mul_next;
				mul_a_q <= {mul_a_q[62:0], 1'b0};
				mul_b_q <= {1'b0, mul_b_q[31:1]};
				step_q  <= step_q + 1'b1;
				if (mul_end) begin
					step_q <= '0;
					case (state_q)
						wrc_pkg::S_N1: begin
							// subtract Sx*Sy as |Sx| times signed Sy
							mul_a_q   <= {{35{sy_q[28]}}, sy_q};
							mul_b_q   <= {3'd0, sx_mag};
							mul_sub_q <= !sx_q[28];
						end
						wrc_pkg::S_N2: begin
							neg_q     <= mul_next[63];
							dvd_q     <= {num_mag[55:0], 19'd0};
							acc_q     <= '0;
							mul_a_q   <= {{20{sxx_q[43]}}, sxx_q};
							mul_b_q   <= {19'd0, cnt_q};
							mul_sub_q <= 1'b0;
						end
						wrc_pkg::S_D1: begin
							mul_a_q   <= {35'd0, sx_mag};
							mul_b_q   <= {3'd0, sx_mag};
							mul_sub_q <= 1'b1;
						end
						wrc_pkg::S_D2: begin
							dvs_q  <= mul_next[62:0];
							rem_q  <= '0;
							quo_q  <= '0;
							qovf_q <= 1'b0;
							if (den_bad) status_q <= wrc_pkg::ST_ZERO_DEN;
						end
						wrc_pkg::S_PC: begin
							dvd_q     <= {1'b0, mul_next[31:0], 42'd0};
							acc_q     <= '0;
							mul_a_q   <= wrc_pkg::PI_SCALE;
							mul_b_q   <= slope_q[31] ? (32'd0 - slope_q) : slope_q;
							mul_sub_q <= 1'b0;
						end
						default: begin
							// S_KD: divisor is |slope| * 0.6pi
							dvs_q  <= mul_next[62:0];
							rem_q  <= '0;
							quo_q  <= '0;
							qovf_q <= 1'b0;
						end
					endcase
				end
			end
			wrc_pkg::S_DIVS, wrc_pkg::S_DIVK: begin
				// one restoring divide step, quotient saturates
				rem_q  <= alu_cout ? alu_sum[62:0] : rem_sh[62:0];
				quo_q  <= {quo_q[31:0], alu_cout};
				qovf_q <= qovf_q | quo_q[32];
				dvd_q  <= {dvd_q[wrc_pkg::DVD_W-2:0], 1'b0};
				step_q <= div_end ? 7'd0 : step_q + 1'b1;
			end
			wrc_pkg::S_SLP: begin
				slope_q   <= q_val;
				neg_q     <= q_val[31];
				acc_q     <= '0;
				step_q    <= '0;
				mul_a_q   <= {48'd0, power_q};
				mul_b_q   <= {16'd0, cal_q};
				mul_sub_q <= 1'b0;
				if (q_val == 32'sd0) status_q <= wrc_pkg::ST_ZERO_DEN;
			end
			wrc_pkg::S_KOUT: k_q <= q_val;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			result_q.slope        <= slope_q;
			result_q.conductivity <= k_q;
			result_q.status       <= status_q;
			result_q.points_used  <= used_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != wrc_pkg::ST_OK |->
		result.slope == 32'sd0 && result.conductivity == 32'sd0)
		else $error("error result carries nonzero values");

	a_ok_slope: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == wrc_pkg::ST_OK |-> result.slope != 32'sd0)
		else $error("ok result with zero slope");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wrc_pkg::CNT_W'(wrc_pkg::MAX_POINTS))
		else $error("point count beyond limit");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while previous in work");
`endif

endmodule

// ===== design/wrc_alu.sv =====
module wrc_alu (
	input  wrc_pkg::alu_req_t req,
	output logic [63:0]       sum,
	output logic              cout
);

	// a + b or a - b; carry out high means a >= b on subtract
	logic [63:0] b_op;

	assign b_op = req.sub ? ~req.b : req.b;
	assign {cout, sum} = {1'b0, req.a} + {1'b0, b_op} + {64'd0, req.sub};

endmodule

// ===== design/wrc_mul.sv =====
module wrc_mul (
	input  logic               clk,
	input  logic signed [15:0] a,
	input  logic signed [15:0] b,
	output logic signed [31:0] prod_s1
);

	// registered 16x16 signed product
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

endmodule
